[hdl/rsi_pkg.sv]
package rsi_pkg;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int DIR_WIDTH = 16;
	localparam int DIST_WIDTH = 32;
	localparam int CFG_IDX_W = 2;
	localparam int RADIUS_RESET = 65536;
	localparam int RND_SHIFT = 14;

	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd3;
endpackage

[hdl/rsi_ray_if.sv]
interface rsi_ray_if #(
	parameter int CW = rsi_pkg::COORD_WIDTH_DEF
);
	logic valid;
	logic ready;
	logic signed [CW-1:0] orig_x;
	logic signed [CW-1:0] orig_y;
	logic signed [CW-1:0] orig_z;
	logic signed [rsi_pkg::DIR_WIDTH-1:0] dir_x;
	logic signed [rsi_pkg::DIR_WIDTH-1:0] dir_y;
	logic signed [rsi_pkg::DIR_WIDTH-1:0] dir_z;

	modport source (output valid, orig_x, orig_y, orig_z, dir_x, dir_y, dir_z, input ready);
	modport sink (input valid, orig_x, orig_y, orig_z, dir_x, dir_y, dir_z, output ready);
endinterface

[hdl/rsi_hit_if.sv]
interface rsi_hit_if;
	logic valid;
	logic ready;
	logic hit;
	logic [rsi_pkg::DIST_WIDTH-1:0] distance;

	modport source (output valid, hit, distance, input ready);
	modport sink (input valid, hit, distance, output ready);
endinterface

[hdl/rsi_front.sv]
module rsi_front #(
	parameter int CW = rsi_pkg::COORD_WIDTH_DEF,
	parameter int BW = CW + 5
) (
	input logic clk,
	input logic arst_n,
	input logic signed [CW-1:0] center_x,
	input logic signed [CW-1:0] center_y,
	input logic signed [CW-1:0] center_z,
	input logic [CW-2:0] radius,
	rsi_ray_if.sink ray,
	output logic valid,
	input logic ready,
	output logic neg,
	output logic [2*BW-1:0] rad,
	output logic signed [BW-1:0] b
);
	import rsi_pkg::*;

	localparam int AW = CW + 1;
	localparam int PW = AW + DIR_WIDTH;
	localparam int AAW = 2 * AW + 2;
	localparam int BRW = PW + 2;
	localparam int RRW = 2 * CW - 2;
	localparam int DW = 2 * BW + 2;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	logic signed [AW-1:0] a_s1 [3];
	logic signed [DIR_WIDTH-1:0] d_s1 [3];
	logic signed [2*AW-1:0] pa_s2 [3];
	logic signed [PW-1:0] pd_s2 [3];
	logic [RRW-1:0] rr_s2, rr_s3, rr_s4;
	logic signed [AAW-1:0] aa_s3, aa_s4;
	logic signed [BW-1:0] b_s3, b_s4, b_s5;
	logic signed [2*BW-1:0] bb_s4;
	logic [2*BW-1:0] rad_s5;
	logic neg_s5;

	logic signed [BRW-1:0] braw, brnd;
	logic signed [DW-1:0] disc;

	assign en5 = !v_s5 || ready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign ray.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= ray.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	assign braw = BRW'(pd_s2[0]) + BRW'(pd_s2[1]) + BRW'(pd_s2[2]);
	assign brnd = braw + BRW'(1 << (RND_SHIFT - 1));
	assign disc = DW'(bb_s4) + $signed(DW'(rr_s4)) - DW'(aa_s4);

	always_ff @(posedge clk) begin
		if (en1) begin
			a_s1[0] <= AW'(ray.orig_x) - AW'(center_x);
			a_s1[1] <= AW'(ray.orig_y) - AW'(center_y);
			a_s1[2] <= AW'(ray.orig_z) - AW'(center_z);
			d_s1[0] <= ray.dir_x;
			d_s1[1] <= ray.dir_y;
			d_s1[2] <= ray.dir_z;
		end
		if (en2) begin
			for (int i = 0; i < 3; i++) begin
				pa_s2[i] <= a_s1[i] * a_s1[i];
				pd_s2[i] <= a_s1[i] * d_s1[i];
			end
			rr_s2 <= radius * radius;
		end
		if (en3) begin
			aa_s3 <= AAW'(pa_s2[0]) + AAW'(pa_s2[1]) + AAW'(pa_s2[2]);
			b_s3 <= brnd[BRW-1:RND_SHIFT];
			rr_s3 <= rr_s2;
		end
		if (en4) begin
			bb_s4 <= b_s3 * b_s3;
			aa_s4 <= aa_s3;
			rr_s4 <= rr_s3;
			b_s4 <= b_s3;
		end
		if (en5) begin
			neg_s5 <= disc[DW-1];
			rad_s5 <= disc[2*BW-1:0];
			b_s5 <= b_s4;
		end
	end

	assign valid = v_s5;
	assign neg = neg_s5;
	assign rad = rad_s5;
	assign b = b_s5;
endmodule

[hdl/rsi_sqrt_cell.sv]
module rsi_sqrt_cell #(
	parameter int BW = rsi_pkg::COORD_WIDTH_DEF + 5
) (
	input logic clk,
	input logic arst_n,
	input logic valid_in,
	output logic ready_out,
	input logic neg_in,
	input logic [2*BW-1:0] rad_in,
	input logic [BW+2:0] rem_in,
	input logic [BW-1:0] root_in,
	input logic signed [BW-1:0] b_in,
	output logic valid,
	input logic ready,
	output logic neg,
	output logic [2*BW-1:0] rad,
	output logic [BW+2:0] rem,
	output logic [BW-1:0] root,
	output logic signed [BW-1:0] b
);
	localparam int RW = BW + 3;

	logic v_q, en;
	logic [RW-1:0] cur, trial;
	logic [2*BW-1:0] rad_q;
	logic [RW-1:0] rem_q;
	logic [BW-1:0] root_q;
	logic signed [BW-1:0] b_q;
	logic neg_q;

	assign en = !v_q || ready;
	assign ready_out = en;
	assign cur = {rem_in[RW-3:0], rad_in[2*BW-1:2*BW-2]};
	assign trial = {1'b0, root_in, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q <= {rad_in[2*BW-3:0], 2'b00};
			if (cur >= trial) begin
				rem_q <= cur - trial;
				root_q <= {root_in[BW-2:0], 1'b1};
			end else begin
				rem_q <= cur;
				root_q <= {root_in[BW-2:0], 1'b0};
			end
			b_q <= b_in;
			neg_q <= neg_in;
		end
	end

	assign valid = v_q;
	assign neg = neg_q;
	assign rad = rad_q;
	assign rem = rem_q;
	assign root = root_q;
	assign b = b_q;
endmodule

[hdl/ray_sphere_intersect.sv]
// Ray against sphere test, one ray word per cycle unless the result is stalled.
// ray: origin (signed Q16.16) and unit direction (signed Q1.14) per word.
// result: hit flag and distance (unsigned Q16.16, saturated; 0 on a miss).
// Sphere center and radius are written through wr_en/wr_index/wr_data,
// index 0..2 center x/y/z, 3 radius. Write them only while the block is idle.
// An accepted ray passes five arithmetic stages, then a row of
// COORD_WIDTH + 5 square-root cells, one result bit per cell, then the
// output register.
// Throughput: one ray per cycle when unstalled; every cell hands on its word.
// Each stage stalls only when it is full and the next is stalled, so a
// stalled receiver fills the pipe before ray.ready falls; bubbles are
// squeezed out meanwhile.
// Reset clears all valid flags, the center to 0 and the radius to 1.0.
module ray_sphere_intersect #(
	parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [rsi_pkg::CFG_IDX_W-1:0] wr_index,
	input logic [COORD_WIDTH-1:0] wr_data,
	rsi_ray_if.sink ray,
	rsi_hit_if.source result
);
	import rsi_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int BW = CW + 5;
	localparam int TW = BW + 2;
	localparam int XW = (TW > DIST_WIDTH + 2) ? TW : DIST_WIDTH + 2;

	logic signed [CW-1:0] center_x_q, center_y_q, center_z_q;
	logic [CW-2:0] radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			radius_q <= (CW-1)'(RADIUS_RESET);
		end else if (wr_en) begin
			case (wr_index)
				REG_CENTER_X: center_x_q <= wr_data;
				REG_CENTER_Y: center_y_q <= wr_data;
				REG_CENTER_Z: center_z_q <= wr_data;
				REG_RADIUS: radius_q <= wr_data[CW-2:0];
				default: ;
			endcase
		end
	end

	logic c_valid [BW+1];
	logic c_ready [BW+1];
	logic c_neg [BW+1];
	logic [2*BW-1:0] c_rad [BW+1];
	logic [BW+2:0] c_rem [BW+1];
	logic [BW-1:0] c_root [BW+1];
	logic signed [BW-1:0] c_b [BW+1];

	rsi_front #(.CW(CW), .BW(BW)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.center_x(center_x_q),
		.center_y(center_y_q),
		.center_z(center_z_q),
		.radius(radius_q),
		.ray(ray),
		.valid(c_valid[0]),
		.ready(c_ready[0]),
		.neg(c_neg[0]),
		.rad(c_rad[0]),
		.b(c_b[0])
	);
	assign c_rem[0] = '0;
	assign c_root[0] = '0;

	for (genvar g = 0; g < BW; g++) begin : g_cell
		rsi_sqrt_cell #(.BW(BW)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.valid_in(c_valid[g]),
			.ready_out(c_ready[g]),
			.neg_in(c_neg[g]),
			.rad_in(c_rad[g]),
			.rem_in(c_rem[g]),
			.root_in(c_root[g]),
			.b_in(c_b[g]),
			.valid(c_valid[g+1]),
			.ready(c_ready[g+1]),
			.neg(c_neg[g+1]),
			.rad(c_rad[g+1]),
			.rem(c_rem[g+1]),
			.root(c_root[g+1]),
			.b(c_b[g+1])
		);
	end

	logic signed [XW-1:0] t;
	logic t_pos, t_big;
	logic out_v_q, out_en, hit_q;
	logic [DIST_WIDTH-1:0] dist_q;

	assign t = $signed(XW'(c_root[BW])) - XW'(c_b[BW]);
	assign t_pos = !c_neg[BW] && (t > 0);
	assign t_big = t > $signed(XW'({DIST_WIDTH{1'b1}}));
	assign out_en = !out_v_q || result.ready;
	assign c_ready[BW] = out_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_en) begin
			out_v_q <= c_valid[BW];
		end
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			hit_q <= t_pos;
			if (!t_pos) dist_q <= '0;
			else if (t_big) dist_q <= '1;
			else dist_q <= t[DIST_WIDTH-1:0];
		end
	end

	assign result.valid = out_v_q;
	assign result.hit = hit_q;
	assign result.distance = dist_q;

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !hit_q |-> dist_q == '0) else $error("miss with distance");
	a_hit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && hit_q |-> dist_q != '0) else $error("hit at zero distance");
	a_radius_wr: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && wr_index == REG_RADIUS |=> radius_q == $past(wr_data[CW-2:0]))
		else $error("radius write lost");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !result.ready |=> out_v_q && $stable(dist_q))
		else $error("result dropped under stall");
endmodule
